// ===== design/llcpf_pkg.sv =====
// shared constants and register index codes for the laser line column peak finder
package llcpf_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_GAP_ROWS    = 2;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int THR_W   = 8;
    localparam int RUN_W   = 11;
    localparam int INDEX_W = 2;

    localparam logic [RUN_W-1:0] RUN_LIMIT = '1;

    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH      = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT     = CFG_W'(480);
    localparam logic [THR_W-1:0] RESET_BRIGHT_THRESHOLD = THR_W'(140);

    typedef enum logic [INDEX_W-1:0] {
        CFG_IMAGE_WIDTH      = 2'd0,
        CFG_IMAGE_HEIGHT     = 2'd1,
        CFG_BRIGHT_THRESHOLD = 2'd2
    } cfg_index_t;

endpackage

// ===== design/laser_line_column_peak_finder.sv =====
// laser line peak finder: per-column longest bright run kept in a column record memory
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  grey_pixel
//   out      source     out_valid / out_stall column, found, peak_row, run_width, frame_done
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// one pixel per cycle unless out_stall holds one; the column record memory is read
// when a pixel is taken and written back when it leaves the second stage, with a
// bypass of the last write for a column that comes back at once. results are registered.
// reset clears counters and control; records are rebuilt on row 0 of each frame.
// out_stall holds only last-row pixels, and only once the output register is full.
module laser_line_column_peak_finder #(
    parameter int MAX_COLUMNS = llcpf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = llcpf_pkg::DEF_MAX_ROWS,
    parameter int GAP_ROWS    = llcpf_pkg::DEF_GAP_ROWS,
    localparam int CW = $clog2(MAX_COLUMNS),
    localparam int RW = $clog2(MAX_ROWS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [llcpf_pkg::PIX_W-1:0]      grey_pixel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [CW-1:0]                    column,
    output logic                             found,
    output logic [RW-1:0]                    peak_row,
    output logic [llcpf_pkg::RUN_W-1:0]      run_width,
    output logic                             frame_done,
    input  logic                             cfg_we,
    input  logic [llcpf_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [llcpf_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CSW = (CW + 1 > llcpf_pkg::CFG_W) ? CW + 1 : llcpf_pkg::CFG_W;
    localparam int RSW = (RW + 1 > llcpf_pkg::CFG_W) ? RW + 1 : llcpf_pkg::CFG_W;
    localparam int GW  = RW + 4;

    typedef struct packed {
        logic [llcpf_pkg::RUN_W-1:0] cur_run;
        logic [llcpf_pkg::RUN_W-1:0] best_run;
        logic [RW-1:0]               peak_row;
        logic [RW-1:0]               prev_row;
    } rec_t;

    // configuration
    logic [llcpf_pkg::CFG_W-1:0] width_reg;
    logic [llcpf_pkg::CFG_W-1:0] height_reg;
    logic [llcpf_pkg::THR_W-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= llcpf_pkg::RESET_IMAGE_WIDTH;
            height_reg    <= llcpf_pkg::RESET_IMAGE_HEIGHT;
            threshold_reg <= llcpf_pkg::RESET_BRIGHT_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                llcpf_pkg::CFG_IMAGE_WIDTH:      width_reg     <= cfg_data;
                llcpf_pkg::CFG_IMAGE_HEIGHT:     height_reg    <= cfg_data;
                llcpf_pkg::CFG_BRIGHT_THRESHOLD: threshold_reg <= cfg_data[llcpf_pkg::THR_W-1:0];
                default:                         ;
            endcase
        end
    end

    // last column and row index after clamping the sizes
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (CSW'(width_reg) > CSW'(MAX_COLUMNS))
            w_last = CW'(MAX_COLUMNS - 1);
        else
            w_last = CW'(CSW'(width_reg) - CSW'(1));

        if (height_reg == '0)
            h_last = '0;
        else if (RSW'(height_reg) > RSW'(MAX_ROWS))
            h_last = RW'(MAX_ROWS - 1);
        else
            h_last = RW'(RSW'(height_reg) - RSW'(1));
    end

    // position of the next pixel
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] in_col;
    logic [RW-1:0] in_row;
    logic          in_last_col;
    logic          in_last_row;
    logic          in_accept;

    // second stage: record read data is valid here
    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_last_col_reg;
    logic          s1_last_row_reg;
    logic          s1_bright_reg;
    logic          s1_fire;
    logic          out_free;

    // last record written, for a column read in the same cycle it was written
    logic          lw_valid_reg;
    logic [CW-1:0] lw_col_reg;
    rec_t          lw_rec_reg;

    rec_t rec_mem [MAX_COLUMNS];
    rec_t rd_rec_reg;
    rec_t base_rec;
    rec_t upd_rec;

    // output register
    logic                        out_valid_reg;
    logic [CW-1:0]               column_reg;
    logic                        found_reg;
    logic [RW-1:0]               peak_row_reg;
    logic [llcpf_pkg::RUN_W-1:0] run_width_reg;
    logic                        frame_done_reg;

    assign in_last_col = (col_cnt_reg >= w_last);
    assign in_last_row = (row_cnt_reg >= h_last);
    assign in_col      = in_last_col ? w_last : col_cnt_reg;
    assign in_row      = in_last_row ? h_last : row_cnt_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!s1_last_row_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = in_last_row ? '0 : in_row + 1'b1;
        end
        else
        begin
            col_cnt_next = in_col + 1'b1;
            row_cnt_next = in_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg      <= in_col;
            s1_row_reg      <= in_row;
            s1_last_col_reg <= in_last_col;
            s1_last_row_reg <= in_last_row;
            s1_bright_reg   <= (grey_pixel > threshold_reg);
        end
    end

    // record memory, read-before-write
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            rec_mem[s1_col_reg] <= upd_rec;
        if (in_accept)
            rd_rec_reg <= rec_mem[in_col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lw_valid_reg <= 1'b0;
        else if (s1_fire)
            lw_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            lw_col_reg <= s1_col_reg;
            lw_rec_reg <= upd_rec;
        end
    end

    // read, modify
    always_comb
    begin
        if (s1_row_reg == '0)
            base_rec = '0;
        else if (lw_valid_reg && (lw_col_reg == s1_col_reg))
            base_rec = lw_rec_reg;
        else
            base_rec = rd_rec_reg;

        upd_rec = base_rec;
        if (s1_bright_reg)
        begin
            if (GW'(s1_row_reg) <= GW'(base_rec.prev_row) + GW'(GAP_ROWS))
            begin
                if (base_rec.cur_run < llcpf_pkg::RUN_LIMIT)
                    upd_rec.cur_run = base_rec.cur_run + 1'b1;
            end
            else
                upd_rec.cur_run = llcpf_pkg::RUN_W'(1);
            upd_rec.prev_row = s1_row_reg;
            if (upd_rec.cur_run > base_rec.best_run)
            begin
                upd_rec.best_run = upd_rec.cur_run;
                upd_rec.peak_row = s1_row_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_row_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_row_reg)
        begin
            column_reg     <= s1_col_reg;
            found_reg      <= (upd_rec.peak_row != '0);
            peak_row_reg   <= upd_rec.peak_row;
            run_width_reg  <= upd_rec.best_run;
            frame_done_reg <= s1_last_col_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign column     = column_reg;
    assign found      = found_reg;
    assign peak_row   = peak_row_reg;
    assign run_width  = run_width_reg;
    assign frame_done = frame_done_reg;

endmodule

// ===== tb/llcpf_checker.sv =====
// column peak scoreboard: mirrors the per-column run records and checks every result word
module llcpf_checker #(
    parameter int COL_W = $clog2(llcpf_pkg::DEF_MAX_COLUMNS),
    parameter int ROW_W = $clog2(llcpf_pkg::DEF_MAX_ROWS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [llcpf_pkg::PIX_W-1:0]     grey_pixel,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [COL_W-1:0]                column,
    input  logic                            found,
    input  logic [ROW_W-1:0]                peak_row,
    input  logic [llcpf_pkg::RUN_W-1:0]     run_width,
    input  logic                            frame_done,
    input  logic                            cfg_we,
    input  logic [llcpf_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [llcpf_pkg::CFG_W-1:0]     cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import llcpf_pkg::*;

    localparam int unsigned MAX_COLS = DEF_MAX_COLUMNS;
    localparam int unsigned MAX_LINES = DEF_MAX_ROWS;
    localparam int unsigned GAP = DEF_GAP_ROWS;

    typedef struct {
        logic [COL_W-1:0] column;
        logic             found;
        logic [ROW_W-1:0] peak_row;
        logic [RUN_W-1:0] run_width;
        logic             frame_done;
    } column_peak_t;

    column_peak_t peak_queue[$];

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [THR_W-1:0] threshold_reg;
    int unsigned      row_pos;
    int unsigned      col_pos;
    int               fail_count = 0;
    int               waiting = 0;

    logic [RUN_W-1:0] run_now    [MAX_COLS];
    logic [RUN_W-1:0] run_best   [MAX_COLS];
    logic [ROW_W-1:0] best_row   [MAX_COLS];
    logic [ROW_W-1:0] bright_row [MAX_COLS];

    assign mismatches = fail_count;
    assign pending = waiting;

    // size register as the block uses it: zero means one, oversize means the maximum
    function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == '0)
            return 1;
        if (32'(v) > limit)
            return limit;
        return 32'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic take_pixel(input logic [PIX_W-1:0] g);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        column_peak_t res;
        w = span(width_reg, MAX_COLS);
        h = span(height_reg, MAX_LINES);
        c = (col_pos >= w - 1) ? w - 1 : col_pos;
        r = (row_pos >= h - 1) ? h - 1 : row_pos;
        if (r == 0)
        begin
            run_now[c] = '0;
            run_best[c] = '0;
            best_row[c] = '0;
            bright_row[c] = '0;
        end
        if (g > threshold_reg)
        begin
            if (r <= 32'(bright_row[c]) + GAP)
            begin
                if (run_now[c] != RUN_LIMIT)
                    run_now[c] = run_now[c] + RUN_W'(1);
            end
            else
            begin
                run_now[c] = RUN_W'(1);
            end
            bright_row[c] = ROW_W'(r);
            if (run_now[c] > run_best[c])
            begin
                run_best[c] = run_now[c];
                best_row[c] = ROW_W'(r);
            end
        end
        if (r == h - 1)
        begin
            res.column = COL_W'(c);
            res.found = (best_row[c] != '0);
            res.peak_row = best_row[c];
            res.run_width = run_best[c];
            res.frame_done = (c == w - 1);
            peak_queue.insert(peak_queue.size(), res);
        end
        if (c == w - 1)
        begin
            col_pos = 0;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic check_result();
        column_peak_t want;
        if (peak_queue.size() == 0)
        begin
            report_mismatch($sformatf("result for column %0d with none expected", column));
        end
        else
        begin
            want = peak_queue.pop_front();
            if (column !== want.column)
                report_mismatch($sformatf("column got %0d want %0d", column, want.column));
            if (found !== want.found)
                report_mismatch($sformatf("col %0d found got %0b want %0b",
                                          want.column, found, want.found));
            if (peak_row !== want.peak_row)
                report_mismatch($sformatf("col %0d peak_row got %0d want %0d",
                                          want.column, peak_row, want.peak_row));
            if (run_width !== want.run_width)
                report_mismatch($sformatf("col %0d run_width got %0d want %0d",
                                          want.column, run_width, want.run_width));
            if (frame_done !== want.frame_done)
                report_mismatch($sformatf("col %0d frame_done got %0b want %0b",
                                          want.column, frame_done, want.frame_done));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = RESET_IMAGE_WIDTH;
            height_reg = RESET_IMAGE_HEIGHT;
            threshold_reg = RESET_BRIGHT_THRESHOLD;
            row_pos = 0;
            col_pos = 0;
            peak_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:      width_reg = cfg_data;
                    CFG_IMAGE_HEIGHT:     height_reg = cfg_data;
                    CFG_BRIGHT_THRESHOLD: threshold_reg = cfg_data[THR_W-1:0];
                    default:              ;
                endcase
            end
            if (in_valid && !in_stall)
                take_pixel(grey_pixel);
            if (out_valid && !out_stall)
                check_result();
        end
        waiting = peak_queue.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top: drives pixel frames and register writes around the peak finder, gives the verdict
module tb;
    import llcpf_pkg::*;

    localparam int COL_W = $clog2(DEF_MAX_COLUMNS);
    localparam int ROW_W = $clog2(DEF_MAX_ROWS);
    localparam int RANDOM_ITEMS = 1850;
    localparam int TALL_ROWS = DEF_MAX_ROWS / 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [INDEX_W-1:0] SPARE_INDEX = 2'd3;
    localparam logic [CFG_W-1:0] CFG_ALL_ONES = '1;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } stall_mode_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [PIX_W-1:0]    grey_pixel = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COL_W-1:0]    column;
    logic                found;
    logic [ROW_W-1:0]    peak_row;
    logic [RUN_W-1:0]    run_width;
    logic                frame_done;
    logic                cfg_we = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    int                  mismatches;
    int                  pending;
    int unsigned         cycle_count = 0;
    int                  burst_left = 0;
    int                  stall_left = 0;
    stall_mode_t         stall_mode = STALL_NONE;
    logic [THR_W-1:0]    cur_threshold = RESET_BRIGHT_THRESHOLD;

    laser_line_column_peak_finder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .grey_pixel (grey_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .column     (column),
        .found      (found),
        .peak_row   (peak_row),
        .run_width  (run_width),
        .frame_done (frame_done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    llcpf_checker #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) peak_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .grey_pixel (grey_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .column     (column),
        .found      (found),
        .peak_row   (peak_row),
        .run_width  (run_width),
        .frame_done (frame_done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side backpressure, changes character after each random spell
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 160);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_left % 12) < 9);
        endcase
    end

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int w, input int h, input int thr);
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        cur_threshold = THR_W'(thr);
        write_reg(CFG_BRIGHT_THRESHOLD, {3'($urandom_range(0, 7)), cur_threshold});
    endtask

    // one pixel word, with bursts and random gaps in front of each burst
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 300)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        grey_pixel <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // drain results, then let the write-back pipe settle before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] laser_grey(input int pct, input logic [THR_W-1:0] thr);
        if (pct < 100 && $urandom_range(0, 15) == 0)
            return PIX_W'($urandom_range(0, 255));
        if ($urandom_range(1, 100) <= pct && thr != '1)
            return PIX_W'($urandom_range(thr + 1, 255));
        return PIX_W'($urandom_range(0, thr));
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_density();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 15;
            2:       return 50;
            3:       return 85;
            4:       return 100;
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    // a whole raster frame; optionally the threshold moves somewhere inside it
    task automatic send_frame(input int cols, input int rows, input int pct, input bit thr_swap);
        int total;
        int swap_at;
        total = cols * rows;
        swap_at = thr_swap ? $urandom_range(0, total - 1) : -1;
        for (int i = 0; i < total; i++)
        begin
            if (i == swap_at)
            begin
                wait_idle();
                cur_threshold = THR_W'($urandom_range(0, 255));
                write_reg(CFG_BRIGHT_THRESHOLD, {3'($urandom_range(0, 7)), cur_threshold});
            end
            send_pixel(laser_grey(pct, cur_threshold));
        end
    endtask

    initial
    begin
        logic [PIX_W-1:0] runs_grid [9] = '{255, 140, 200, 141, 140, 0, 255, 140, 0};
        logic [PIX_W-1:0] gap_column [6] = '{200, 0, 141, 0, 0, 200};
        logic [PIX_W-1:0] tall_start [8] = '{101, 100, 101, 255, 255, 0, 101, 101};
        int  random_items;
        int  cols;
        int  rows;
        bit  wide_done;
        bit  tall_done;

        random_items = 0;
        wide_done = 1'b0;
        tall_done = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // threshold boundary, full run, dark column, longest run only on row 0
        configure(3, 3, 140);
        foreach (runs_grid[i])
            send_pixel(runs_grid[i]);
        wait_idle();

        // gap of exactly two rows extends, a wider gap restarts
        configure(1, 6, 140);
        foreach (gap_column[i])
            send_pixel(gap_column[i]);
        wait_idle();

        // width shrinks inside row 0: column counter lands past the new last column
        configure(1024, 2, 0);
        send_pixel(PIX_W'(0));
        send_pixel(PIX_W'(1));
        send_pixel(PIX_W'(255));
        send_pixel(PIX_W'(0));
        send_pixel(PIX_W'(7));
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(3));
        cur_threshold = '1;
        write_reg(CFG_BRIGHT_THRESHOLD, {3'b000, cur_threshold});
        write_reg(SPARE_INDEX, CFG_ALL_ONES);
        send_pixel(PIX_W'(128));
        repeat (3) send_pixel(PIX_W'(255));
        wait_idle();

        // oversize height, then shrinks below the current row
        configure(2, 2047, 100);
        foreach (tall_start[i])
            send_pixel(tall_start[i]);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(3));
        send_pixel(PIX_W'(255));
        send_pixel(PIX_W'(0));
        wait_idle();

        while (random_items < RANDOM_ITEMS || !wide_done || !tall_done)
        begin
            wait_idle();
            if (!wide_done && random_items >= RANDOM_ITEMS / 6)
            begin
                configure(CFG_ALL_ONES, 0, pick_threshold());
                send_frame(DEF_MAX_COLUMNS, 1, pick_density(), 1'b0);
                random_items += DEF_MAX_COLUMNS;
                wide_done = 1'b1;
            end
            else if (!tall_done && random_items >= 2 * RANDOM_ITEMS / 3)
            begin
                configure(0, TALL_ROWS, $urandom_range(0, 254));
                send_frame(1, TALL_ROWS, 100, 1'b0);
                random_items += TALL_ROWS;
                tall_done = 1'b1;
            end
            else
            begin
                cols = $urandom_range(0, 12);
                rows = $urandom_range(0, 10);
                configure(cols, rows, pick_threshold());
                if (cols == 0)
                    cols = 1;
                if (rows == 0)
                    rows = 1;
                send_frame(cols, rows, pick_density(), $urandom_range(0, 5) == 0);
                random_items += cols * rows;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/llcpf_pkg.sv
design/laser_line_column_peak_finder.sv
tb/llcpf_checker.sv
tb/tb.sv
